FILE: hw/rtl/cra_pkg.sv
// ----------------------------------------------------------------------------
// cra_pkg
// Shared types and opcode constants of the 6502-style execute stage.
// ----------------------------------------------------------------------------
package cra_pkg;

    // status bit positions, N V - B D I Z C
    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_I = 2;
    localparam int FLAG_D = 3;
    localparam int FLAG_V = 6;
    localparam int FLAG_N = 7;

    // operation field of the accumulator group (op[1:0] == 01)
    localparam logic [2:0] GRP_ORA = 3'd0;
    localparam logic [2:0] GRP_AND = 3'd1;
    localparam logic [2:0] GRP_EOR = 3'd2;
    localparam logic [2:0] GRP_ADC = 3'd3;
    localparam logic [2:0] GRP_STA = 3'd4;
    localparam logic [2:0] GRP_LDA = 3'd5;
    localparam logic [2:0] GRP_CMP = 3'd6;
    localparam logic [2:0] GRP_SBC = 3'd7;

    // shift kinds (op[6:5] of the shift group)
    localparam logic [1:0] SH_ASL = 2'd0;
    localparam logic [1:0] SH_ROL = 2'd1;
    localparam logic [1:0] SH_LSR = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    localparam logic [1:0] CC_ACC   = 2'b01;
    localparam logic [1:0] CC_SHIFT = 2'b10;
    localparam logic [2:0] MODE_ACC = 3'd2;
    localparam logic [2:0] GRP_INC  = 3'd7;

    localparam logic [7:0] OP_STA_IMM = 8'h89;
    localparam logic [7:0] OP_LDX_IMM = 8'hA2;
    localparam logic [7:0] OP_LDX_ZP  = 8'hA6;
    localparam logic [7:0] OP_LDX_ZPY = 8'hB6;
    localparam logic [7:0] OP_LDX_ABS = 8'hAE;
    localparam logic [7:0] OP_LDX_ABY = 8'hBE;
    localparam logic [7:0] OP_LDY_IMM = 8'hA0;
    localparam logic [7:0] OP_LDY_ZP  = 8'hA4;
    localparam logic [7:0] OP_LDY_ZPX = 8'hB4;
    localparam logic [7:0] OP_LDY_ABS = 8'hAC;
    localparam logic [7:0] OP_LDY_ABX = 8'hBC;
    localparam logic [7:0] OP_STX_ZP  = 8'h86;
    localparam logic [7:0] OP_STX_ZPY = 8'h96;
    localparam logic [7:0] OP_STX_ABS = 8'h8E;
    localparam logic [7:0] OP_STY_ZP  = 8'h84;
    localparam logic [7:0] OP_STY_ZPX = 8'h94;
    localparam logic [7:0] OP_STY_ABS = 8'h8C;
    localparam logic [7:0] OP_TAX     = 8'hAA;
    localparam logic [7:0] OP_TAY     = 8'hA8;
    localparam logic [7:0] OP_TXA     = 8'h8A;
    localparam logic [7:0] OP_TYA     = 8'h98;
    localparam logic [7:0] OP_TXS     = 8'h9A;
    localparam logic [7:0] OP_TSX     = 8'hBA;
    localparam logic [7:0] OP_PHA     = 8'h48;
    localparam logic [7:0] OP_PHP     = 8'h08;
    localparam logic [7:0] OP_PLA     = 8'h68;
    localparam logic [7:0] OP_PLP     = 8'h28;
    localparam logic [7:0] OP_INX     = 8'hE8;
    localparam logic [7:0] OP_INY     = 8'hC8;
    localparam logic [7:0] OP_DEX     = 8'hCA;
    localparam logic [7:0] OP_DEY     = 8'h88;
    localparam logic [7:0] OP_BIT_ZP  = 8'h24;
    localparam logic [7:0] OP_BIT_ABS = 8'h2C;
    localparam logic [7:0] OP_CPX_IMM = 8'hE0;
    localparam logic [7:0] OP_CPX_ZP  = 8'hE4;
    localparam logic [7:0] OP_CPX_ABS = 8'hEC;
    localparam logic [7:0] OP_CPY_IMM = 8'hC0;
    localparam logic [7:0] OP_CPY_ZP  = 8'hC4;
    localparam logic [7:0] OP_CPY_ABS = 8'hCC;
    localparam logic [7:0] OP_CLC     = 8'h18;
    localparam logic [7:0] OP_CLD     = 8'hD8;
    localparam logic [7:0] OP_CLI     = 8'h58;
    localparam logic [7:0] OP_CLV     = 8'hB8;
    localparam logic [7:0] OP_SEC     = 8'h38;
    localparam logic [7:0] OP_SED     = 8'hF8;
    localparam logic [7:0] OP_SEI     = 8'h78;
    localparam logic [7:0] OP_BPL     = 8'h10;
    localparam logic [7:0] OP_BMI     = 8'h30;
    localparam logic [7:0] OP_BVC     = 8'h50;
    localparam logic [7:0] OP_BVS     = 8'h70;
    localparam logic [7:0] OP_BCC     = 8'h90;
    localparam logic [7:0] OP_BCS     = 8'hB0;
    localparam logic [7:0] OP_BNE     = 8'hD0;
    localparam logic [7:0] OP_BEQ     = 8'hF0;

    // decimal-mode adjust constants
    localparam logic [4:0] BCD_NIB_MAX = 5'h09;
    localparam logic [5:0] BCD_NIB_ADJ = 6'h06;
    localparam logic [8:0] BCD_HI_MAX  = 9'h090;
    localparam logic [9:0] BCD_HI_ADJ  = 10'h060;
    localparam logic [8:0] BCD_CARRY   = 9'h010;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] sp;
        logic [7:0] p;
    } t_regs;

    typedef struct packed {
        logic [7:0] result;
        logic       write_back;
        logic [7:0] status;
        logic       branch_taken;
    } t_exec;

endpackage

FILE: hw/rtl/cra_if.sv
// ----------------------------------------------------------------------------
// cra_if
// Valid/ready channels of the execute stage: instructions in, results out.
// ----------------------------------------------------------------------------
interface cra_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] operation;
    logic [7:0] operand;

    modport source (output valid, output operation, output operand, input ready);
    modport sink   (input valid, input operation, input operand, output ready);
endinterface

interface cra_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] result;
    logic       write_back;
    logic [7:0] status;
    logic       branch_taken;

    modport source (output valid, output result, output write_back, output status,
                    output branch_taken, input ready);
    modport sink   (input valid, input result, input write_back, input status,
                    input branch_taken, output ready);
endinterface

FILE: hw/rtl/cra_alu.sv
// ----------------------------------------------------------------------------
// cra_alu
// Decode and execute of one opcode against the register file, single pass.
// ----------------------------------------------------------------------------
module cra_alu
    import cra_pkg::*;
(
    input  logic [7:0] i_operation,
    input  logic [7:0] i_operand,
    input  t_regs      i_regs,
    output t_regs      o_regs,
    output t_exec      o_exec
);

    function automatic logic [7:0] f_nz(input logic [7:0] p, input logic [7:0] v);
        logic [7:0] q;
        q = p;
        q[FLAG_N] = v[7];
        q[FLAG_Z] = (v == 8'h00);
        return q;
    endfunction

    logic [2:0] w_aaa;
    logic [2:0] w_bbb;
    logic [7:0] w_a;
    logic [7:0] w_m;
    logic       w_c;
    logic       w_grp_acc;
    logic       w_grp_shift;
    logic       w_grp_incdec;

    assign w_aaa = i_operation[7:5];
    assign w_bbb = i_operation[4:2];
    assign w_a   = i_regs.a;
    assign w_m   = i_operand;
    assign w_c   = i_regs.p[FLAG_C];

    assign w_grp_acc = (i_operation[1:0] == CC_ACC) && (i_operation != OP_STA_IMM);
    assign w_grp_shift = (i_operation[1:0] == CC_SHIFT) && !w_aaa[2] &&
                         (w_bbb[0] || (w_bbb == MODE_ACC));
    assign w_grp_incdec = (i_operation[1:0] == CC_SHIFT) && (w_aaa[2:1] == 2'b11) &&
                          w_bbb[0];

    // binary add
    logic [8:0] w_add;
    assign w_add = {1'b0, w_a} + {1'b0, w_m} + {8'h00, w_c};

    // decimal add
    logic [5:0] w_dlo;
    logic [5:0] w_dlo_adj;
    logic [8:0] w_dt;
    logic [9:0] w_dt_adj;
    assign w_dlo     = {2'b00, w_a[3:0]} + {2'b00, w_m[3:0]} + {5'h00, w_c};
    assign w_dlo_adj = (w_dlo > {1'b0, BCD_NIB_MAX}) ? w_dlo + BCD_NIB_ADJ : w_dlo;
    assign w_dt = {5'h00, w_dlo_adj[3:0]} + {1'b0, w_a[7:4], 4'h0} +
                  {1'b0, w_m[7:4], 4'h0} + ((w_dlo_adj[5:4] != 2'b00) ? BCD_CARRY : 9'h000);
    assign w_dt_adj = ({w_dt[8:4], 4'h0} > BCD_HI_MAX) ? {1'b0, w_dt} + BCD_HI_ADJ
                                                        : {1'b0, w_dt};

    // binary subtract, borrow in bit 8
    logic [8:0] w_sub;
    assign w_sub = {1'b0, w_a} - {1'b0, w_m} - {8'h00, !w_c};

    // decimal subtract
    logic [4:0] w_slo;
    logic [4:0] w_slo_adj;
    logic [8:0] w_shi;
    logic [8:0] w_sd;
    logic [8:0] w_sd_adj;
    assign w_slo     = {1'b0, w_a[3:0]} - {1'b0, w_m[3:0]} - {4'h0, !w_c};
    assign w_slo_adj = w_slo - 5'd6;
    assign w_shi = {1'b0, w_a[7:4], 4'h0} - {1'b0, w_m[7:4], 4'h0} -
                   (w_slo[4] ? BCD_CARRY : 9'h000);
    assign w_sd     = {w_shi[8:4], (w_slo[4] ? w_slo_adj[3:0] : w_slo[3:0])};
    assign w_sd_adj = w_sd[8] ? w_sd - BCD_HI_ADJ[8:0] : w_sd;

    // compare: CMP uses A, CPX uses X, CPY uses Y
    logic [7:0] w_cmp_reg;
    logic [8:0] w_cmp;
    assign w_cmp_reg = (i_operation[1:0] == CC_ACC) ? w_a :
                       (i_operation[5] ? i_regs.x : i_regs.y);
    assign w_cmp = {1'b0, w_cmp_reg} - {1'b0, w_m};

    // shift unit
    logic [7:0] w_sh_in;
    logic [7:0] w_sh_out;
    logic       w_sh_c;
    assign w_sh_in = (w_bbb == MODE_ACC) ? w_a : w_m;
    always_comb begin
        case (w_aaa[1:0])
            SH_ASL: begin
                w_sh_out = {w_sh_in[6:0], 1'b0};
                w_sh_c   = w_sh_in[7];
            end
            SH_ROL: begin
                w_sh_out = {w_sh_in[6:0], w_c};
                w_sh_c   = w_sh_in[7];
            end
            SH_LSR: begin
                w_sh_out = {1'b0, w_sh_in[7:1]};
                w_sh_c   = w_sh_in[0];
            end
            SH_ROR: begin
                w_sh_out = {w_c, w_sh_in[7:1]};
                w_sh_c   = w_sh_in[0];
            end
            default: begin
                w_sh_out = w_sh_in;
                w_sh_c   = w_c;
            end
        endcase
    end

    logic [7:0] w_mem_incdec;
    assign w_mem_incdec = (w_aaa == GRP_INC) ? w_m + 8'd1 : w_m - 8'd1;

    t_regs      n;
    logic [7:0] n_res;
    logic       n_wr;
    logic       n_br;

    always_comb begin
        n     = i_regs;
        n_res = 8'h00;
        n_wr  = 1'b0;
        n_br  = 1'b0;
        if (w_grp_acc) begin
            case (w_aaa)
                GRP_ORA: begin
                    n.a = w_a | w_m;
                    n.p = f_nz(i_regs.p, w_a | w_m);
                end
                GRP_AND: begin
                    n.a = w_a & w_m;
                    n.p = f_nz(i_regs.p, w_a & w_m);
                end
                GRP_EOR: begin
                    n.a = w_a ^ w_m;
                    n.p = f_nz(i_regs.p, w_a ^ w_m);
                end
                GRP_ADC: begin
                    if (i_regs.p[FLAG_D]) begin
                        n.a         = w_dt_adj[7:0];
                        n.p[FLAG_Z] = (w_add[7:0] == 8'h00);
                        n.p[FLAG_N] = w_dt[7];
                        n.p[FLAG_V] = (w_a[7] ^ w_dt[7]) && !(w_a[7] ^ w_m[7]);
                        n.p[FLAG_C] = (w_dt_adj[9:8] != 2'b00);
                    end else begin
                        n.a         = w_add[7:0];
                        n.p         = f_nz(i_regs.p, w_add[7:0]);
                        n.p[FLAG_V] = !(w_a[7] ^ w_m[7]) && (w_a[7] ^ w_add[7]);
                        n.p[FLAG_C] = w_add[8];
                    end
                end
                GRP_STA: begin
                    n_res = w_a;
                    n_wr  = 1'b1;
                end
                GRP_LDA: begin
                    n.a = w_m;
                    n.p = f_nz(i_regs.p, w_m);
                end
                GRP_CMP: begin
                    n.p         = f_nz(i_regs.p, w_cmp[7:0]);
                    n.p[FLAG_C] = !w_cmp[8];
                end
                GRP_SBC: begin
                    n.p         = f_nz(i_regs.p, w_sub[7:0]);
                    n.p[FLAG_C] = !w_sub[8];
                    n.p[FLAG_V] = (w_a[7] ^ w_sub[7]) && (w_a[7] ^ w_m[7]);
                    n.a         = i_regs.p[FLAG_D] ? w_sd_adj[7:0] : w_sub[7:0];
                end
                default: begin
                    n = i_regs;
                end
            endcase
        end else if (w_grp_shift) begin
            n.p         = f_nz(i_regs.p, w_sh_out);
            n.p[FLAG_C] = w_sh_c;
            if (w_bbb == MODE_ACC) begin
                n.a = w_sh_out;
            end else begin
                n_res = w_sh_out;
                n_wr  = 1'b1;
            end
        end else if (w_grp_incdec) begin
            n.p   = f_nz(i_regs.p, w_mem_incdec);
            n_res = w_mem_incdec;
            n_wr  = 1'b1;
        end else begin
            case (i_operation)
                OP_LDX_IMM, OP_LDX_ZP, OP_LDX_ZPY, OP_LDX_ABS, OP_LDX_ABY: begin
                    n.x = w_m;
                    n.p = f_nz(i_regs.p, w_m);
                end
                OP_LDY_IMM, OP_LDY_ZP, OP_LDY_ZPX, OP_LDY_ABS, OP_LDY_ABX: begin
                    n.y = w_m;
                    n.p = f_nz(i_regs.p, w_m);
                end
                OP_STX_ZP, OP_STX_ZPY, OP_STX_ABS: begin
                    n_res = i_regs.x;
                    n_wr  = 1'b1;
                end
                OP_STY_ZP, OP_STY_ZPX, OP_STY_ABS: begin
                    n_res = i_regs.y;
                    n_wr  = 1'b1;
                end
                OP_TAX: begin
                    n.x = w_a;
                    n.p = f_nz(i_regs.p, w_a);
                end
                OP_TAY: begin
                    n.y = w_a;
                    n.p = f_nz(i_regs.p, w_a);
                end
                OP_TXA: begin
                    n.a = i_regs.x;
                    n.p = f_nz(i_regs.p, i_regs.x);
                end
                OP_TYA: begin
                    n.a = i_regs.y;
                    n.p = f_nz(i_regs.p, i_regs.y);
                end
                OP_TXS: begin
                    n.sp = i_regs.x;
                end
                OP_TSX: begin
                    n.x = i_regs.sp;
                    n.p = f_nz(i_regs.p, i_regs.sp);
                end
                OP_PHA: begin
                    n_res = w_a;
                    n_wr  = 1'b1;
                    n.sp  = i_regs.sp - 8'd1;
                end
                OP_PHP: begin
                    n_res = i_regs.p;
                    n_wr  = 1'b1;
                    n.sp  = i_regs.sp - 8'd1;
                end
                OP_PLA: begin
                    n.sp = i_regs.sp + 8'd1;
                    n.a  = w_m;
                    n.p  = f_nz(i_regs.p, w_m);
                end
                OP_PLP: begin
                    n.sp = i_regs.sp + 8'd1;
                    n.p  = w_m;
                end
                OP_INX: begin
                    n.x = i_regs.x + 8'd1;
                    n.p = f_nz(i_regs.p, i_regs.x + 8'd1);
                end
                OP_INY: begin
                    n.y = i_regs.y + 8'd1;
                    n.p = f_nz(i_regs.p, i_regs.y + 8'd1);
                end
                OP_DEX: begin
                    n.x = i_regs.x - 8'd1;
                    n.p = f_nz(i_regs.p, i_regs.x - 8'd1);
                end
                OP_DEY: begin
                    n.y = i_regs.y - 8'd1;
                    n.p = f_nz(i_regs.p, i_regs.y - 8'd1);
                end
                OP_BIT_ZP, OP_BIT_ABS: begin
                    n.p[FLAG_N] = w_m[7];
                    n.p[FLAG_V] = w_m[6];
                    n.p[FLAG_Z] = ((w_m & w_a) == 8'h00);
                end
                OP_CPX_IMM, OP_CPX_ZP, OP_CPX_ABS, OP_CPY_IMM, OP_CPY_ZP, OP_CPY_ABS: begin
                    n.p         = f_nz(i_regs.p, w_cmp[7:0]);
                    n.p[FLAG_C] = !w_cmp[8];
                end
                OP_CLC: n.p[FLAG_C] = 1'b0;
                OP_CLD: n.p[FLAG_D] = 1'b0;
                OP_CLI: n.p[FLAG_I] = 1'b0;
                OP_CLV: n.p[FLAG_V] = 1'b0;
                OP_SEC: n.p[FLAG_C] = 1'b1;
                OP_SED: n.p[FLAG_D] = 1'b1;
                OP_SEI: n.p[FLAG_I] = 1'b1;
                OP_BPL: n_br = !i_regs.p[FLAG_N];
                OP_BMI: n_br = i_regs.p[FLAG_N];
                OP_BVC: n_br = !i_regs.p[FLAG_V];
                OP_BVS: n_br = i_regs.p[FLAG_V];
                OP_BCC: n_br = !i_regs.p[FLAG_C];
                OP_BCS: n_br = i_regs.p[FLAG_C];
                OP_BNE: n_br = !i_regs.p[FLAG_Z];
                OP_BEQ: n_br = i_regs.p[FLAG_Z];
                default: begin
                    n = i_regs;
                end
            endcase
        end
    end

    assign o_regs              = n;
    assign o_exec.result       = n_res;
    assign o_exec.write_back   = n_wr;
    assign o_exec.status       = n.p;
    assign o_exec.branch_taken = n_br;

endmodule

FILE: hw/rtl/cpu_register_alu_execute.sv
// ----------------------------------------------------------------------------
// cpu_register_alu_execute
// Execute stage of a 6502-style core: holds A, X, Y, SP and P, runs one
// resolved instruction per transaction and reports write-back and flags.
//
//   channel  dir  modport  payload
//   i_in     in   sink     operation[7:0], operand[7:0]
//   o_out    out  source   result[7:0], write_back, status[7:0], branch_taken
//
// Two register stages: an instruction register and a result register, with
// the decode/ALU between them. One instruction per cycle while o_out does not
// stall. Registers update at the edge the instruction moves into the result
// register, so the instruction behind it sees them without any bubble.
// Reset (synchronous, low) clears A, X, Y, SP, P and both stage valids.
// A stall on o_out holds the result; i_in keeps accepting until both stages fill.
// ----------------------------------------------------------------------------
module cpu_register_alu_execute
    import cra_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    cra_in_if.sink   i_in,
    cra_out_if.source o_out
);

    logic       r_in_valid;
    logic [7:0] r_in_op;
    logic [7:0] r_in_opd;
    logic       r_out_valid;
    t_exec      r_out;
    t_regs      r_regs;

    t_regs      n_regs;
    t_exec      n_exec;

    logic       w_advance;
    logic       w_in_take;

    cra_alu u_alu (
        .i_operation (r_in_op),
        .i_operand   (r_in_opd),
        .i_regs      (r_regs),
        .o_regs      (n_regs),
        .o_exec      (n_exec)
    );

    assign w_advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_advance;
    assign w_in_take  = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_regs      <= '0;
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_regs      <= n_regs;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_op  <= i_in.operation;
            r_in_opd <= i_in.operand;
        end
        if (w_advance) begin
            r_out <= n_exec;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.result       = r_out.result;
    assign o_out.write_back   = r_out.write_back;
    assign o_out.status       = r_out.status;
    assign o_out.branch_taken = r_out.branch_taken;

    // a full instruction register only accepts when it drains in the same cycle
    a_in_full_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_take && r_in_valid) |-> w_advance)
        else $error("instruction accepted over a held one");

    a_advance_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> (r_out_valid && (o_out.status == r_regs.p)))
        else $error("result not presented with the updated flags");

    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.write_back) |-> (r_out.result == 8'h00))
        else $error("result byte set without write-back");

    a_branch_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.branch_taken) |-> !r_out.write_back)
        else $error("branch reported together with a write");

endmodule

FILE: tb/tb_cpu_register_alu_execute.sv
// ----------------------------------------------------------------------------
// tb_cpu_register_alu_execute
// Self-checking bench for the 6502-style execute stage. A scoreboard keeps its
// own copy of A, X, Y, SP and P, predicts write-back, status and branch bits
// for every accepted instruction and checks each result in order. Stimulus is
// a directed opening followed by random instructions biased toward documented
// opcodes, with random idle and stall bursts on both channels.
// ----------------------------------------------------------------------------
module tb_cpu_register_alu_execute
    import cra_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1300;
    localparam int QUIET_TAIL   = 150;
    localparam int DRAIN_CYCLES = 10;

    // opcodes used by the directed part that the package does not name
    localparam logic [7:0] OP_LDA_IMM  = 8'hA9;
    localparam logic [7:0] OP_ORA_IMM  = 8'h09;
    localparam logic [7:0] OP_EOR_IMM  = 8'h49;
    localparam logic [7:0] OP_ADC_IMM  = 8'h69;
    localparam logic [7:0] OP_SBC_IMM  = 8'hE9;
    localparam logic [7:0] OP_CMP_IMM  = 8'hC9;
    localparam logic [7:0] OP_STA_ABS  = 8'h8D;
    localparam logic [7:0] OP_ASL_ACC  = 8'h0A;
    localparam logic [7:0] OP_ROR_ABS  = 8'h6E;
    localparam logic [7:0] OP_INC_ABS  = 8'hEE;
    localparam logic [7:0] OP_DEC_ABS  = 8'hCE;
    localparam logic [7:0] OP_JMP_ABS  = 8'h4C;
    localparam logic [7:0] OP_UNDOC_FF = 8'hFF;

    class exec_scoreboard;
        logic [7:0] acc;
        logic [7:0] ix;
        logic [7:0] iy;
        logic [7:0] sp;
        logic [7:0] p;
        t_exec      expected_exec[$];
        int         errors;

        function new();
            acc = 8'h00;
            ix = 8'h00;
            iy = 8'h00;
            sp = 8'h00;
            p = 8'h00;
            errors = 0;
        endfunction

        function logic [7:0] set_nz(logic [7:0] b);
            p[FLAG_N] = b[7];
            p[FLAG_Z] = (b == 8'h00);
            return b;
        endfunction

        function void compare_reg(logic [7:0] r, logic [7:0] m);
            p[FLAG_C] = (r >= m);
            void'(set_nz(r - m));
        endfunction

        function void add_with_carry(logic [7:0] m);
            logic [31:0] a;
            logic [31:0] s;
            logic [31:0] c;
            logic [31:0] t;
            a = {24'd0, acc};
            s = {24'd0, m};
            c = {31'd0, p[FLAG_C]};
            if (p[FLAG_D]) begin
                t = (a & 32'hf) + (s & 32'hf) + c;
                if (t > 32'h9) t = t + 32'h6;
                if (t <= 32'hf) t = (t & 32'hf) + (a & 32'hf0) + (s & 32'hf0);
                else t = (t & 32'hf) + (a & 32'hf0) + (s & 32'hf0) + 32'h10;
                // Z from the binary sum, N and V before the high-nibble adjust
                p[FLAG_Z] = (((a + s + c) & 32'hff) == 32'h0);
                p[FLAG_N] = t[7];
                p[FLAG_V] = (a[7] ^ t[7]) && !(a[7] ^ s[7]);
                if ((t & 32'h1f0) > 32'h90) t = t + 32'h60;
                p[FLAG_C] = ((t & 32'hff0) > 32'hf0);
            end else begin
                t = a + s + c;
                void'(set_nz(t[7:0]));
                p[FLAG_V] = !(a[7] ^ s[7]) && (a[7] ^ t[7]);
                p[FLAG_C] = (t > 32'hff);
            end
            acc = t[7:0];
        endfunction

        function void sub_with_borrow(logic [7:0] m);
            logic [31:0] a;
            logic [31:0] s;
            logic [31:0] b;
            logic [31:0] t;
            logic [31:0] d;
            a = {24'd0, acc};
            s = {24'd0, m};
            b = {31'd0, !p[FLAG_C]};
            t = (a - s - b) & 32'hffff;
            // flags always come from the binary difference
            void'(set_nz(t[7:0]));
            p[FLAG_C] = (t < 32'h100);
            p[FLAG_V] = (a[7] ^ t[7]) && (a[7] ^ s[7]);
            if (p[FLAG_D]) begin
                d = (a & 32'hf) - (s & 32'hf) - b;
                if (d[4]) d = ((d - 32'h6) & 32'hf) | ((a & 32'hf0) - (s & 32'hf0) - 32'h10);
                else d = (d & 32'hf) | ((a & 32'hf0) - (s & 32'hf0));
                if (d[8]) d = d - 32'h60;
                acc = d[7:0];
            end else begin
                acc = t[7:0];
            end
        endfunction

        function logic [7:0] shift_rotate(logic [1:0] kind, logic [7:0] v);
            logic       cin;
            logic [7:0] r;
            cin = p[FLAG_C];
            case (kind)
                SH_ASL: begin
                    p[FLAG_C] = v[7];
                    r = {v[6:0], 1'b0};
                end
                SH_ROL: begin
                    p[FLAG_C] = v[7];
                    r = {v[6:0], cin};
                end
                SH_LSR: begin
                    p[FLAG_C] = v[0];
                    r = {1'b0, v[7:1]};
                end
                default: begin
                    p[FLAG_C] = v[0];
                    r = {cin, v[7:1]};
                end
            endcase
            return set_nz(r);
        endfunction

        // execute one accepted instruction and queue its expected result
        function void note_instruction(logic [7:0] op, logic [7:0] m);
            t_exec      e;
            logic [7:0] res;
            logic       wr;
            logic       br;
            logic [2:0] grp;
            logic [2:0] mode;
            res = 8'h00;
            wr = 1'b0;
            br = 1'b0;
            grp = op[7:5];
            mode = op[4:2];
            if (op[1:0] == CC_ACC && op != OP_STA_IMM) begin
                case (grp)
                    GRP_ORA: acc = set_nz(acc | m);
                    GRP_AND: acc = set_nz(acc & m);
                    GRP_EOR: acc = set_nz(acc ^ m);
                    GRP_ADC: add_with_carry(m);
                    GRP_STA: begin
                        res = acc;
                        wr = 1'b1;
                    end
                    GRP_LDA: acc = set_nz(m);
                    GRP_CMP: compare_reg(acc, m);
                    default: sub_with_borrow(m);
                endcase
            end else if (op[1:0] == CC_SHIFT && !grp[2] && (mode[0] || mode == MODE_ACC)) begin
                if (mode == MODE_ACC) begin
                    acc = shift_rotate(grp[1:0], acc);
                end else begin
                    res = shift_rotate(grp[1:0], m);
                    wr = 1'b1;
                end
            end else if (op[1:0] == CC_SHIFT && grp[2:1] == 2'b11 && mode[0]) begin
                res = set_nz((grp == GRP_INC) ? m + 8'd1 : m - 8'd1);
                wr = 1'b1;
            end else begin
                case (op)
                    OP_LDX_IMM, OP_LDX_ZP, OP_LDX_ZPY, OP_LDX_ABS, OP_LDX_ABY:
                        ix = set_nz(m);
                    OP_LDY_IMM, OP_LDY_ZP, OP_LDY_ZPX, OP_LDY_ABS, OP_LDY_ABX:
                        iy = set_nz(m);
                    OP_STX_ZP, OP_STX_ZPY, OP_STX_ABS: begin
                        res = ix;
                        wr = 1'b1;
                    end
                    OP_STY_ZP, OP_STY_ZPX, OP_STY_ABS: begin
                        res = iy;
                        wr = 1'b1;
                    end
                    OP_TAX: ix = set_nz(acc);
                    OP_TAY: iy = set_nz(acc);
                    OP_TXA: acc = set_nz(ix);
                    OP_TYA: acc = set_nz(iy);
                    OP_TXS: sp = ix;
                    OP_TSX: ix = set_nz(sp);
                    OP_PHA: begin
                        res = acc;
                        wr = 1'b1;
                        sp = sp - 8'd1;
                    end
                    OP_PHP: begin
                        res = p;
                        wr = 1'b1;
                        sp = sp - 8'd1;
                    end
                    OP_PLA: begin
                        sp = sp + 8'd1;
                        acc = set_nz(m);
                    end
                    OP_PLP: begin
                        sp = sp + 8'd1;
                        p = m;
                    end
                    OP_INX: ix = set_nz(ix + 8'd1);
                    OP_INY: iy = set_nz(iy + 8'd1);
                    OP_DEX: ix = set_nz(ix - 8'd1);
                    OP_DEY: iy = set_nz(iy - 8'd1);
                    OP_BIT_ZP, OP_BIT_ABS: begin
                        p[FLAG_N] = m[7];
                        p[FLAG_V] = m[6];
                        p[FLAG_Z] = ((m & acc) == 8'h00);
                    end
                    OP_CPX_IMM, OP_CPX_ZP, OP_CPX_ABS: compare_reg(ix, m);
                    OP_CPY_IMM, OP_CPY_ZP, OP_CPY_ABS: compare_reg(iy, m);
                    OP_CLC: p[FLAG_C] = 1'b0;
                    OP_CLD: p[FLAG_D] = 1'b0;
                    OP_CLI: p[FLAG_I] = 1'b0;
                    OP_CLV: p[FLAG_V] = 1'b0;
                    OP_SEC: p[FLAG_C] = 1'b1;
                    OP_SED: p[FLAG_D] = 1'b1;
                    OP_SEI: p[FLAG_I] = 1'b1;
                    OP_BPL: br = !p[FLAG_N];
                    OP_BMI: br = p[FLAG_N];
                    OP_BVC: br = !p[FLAG_V];
                    OP_BVS: br = p[FLAG_V];
                    OP_BCC: br = !p[FLAG_C];
                    OP_BCS: br = p[FLAG_C];
                    OP_BNE: br = !p[FLAG_Z];
                    OP_BEQ: br = p[FLAG_Z];
                    default: ;
                endcase
            end
            e.result = res;
            e.write_back = wr;
            e.status = p;
            e.branch_taken = br;
            expected_exec.push_back(e);
        endfunction

        function void check_result(t_exec got);
            t_exec w;
            if (expected_exec.size() == 0) begin
                $error("result with no pending instruction: result %h status %h",
                       got.result, got.status);
                errors++;
                return;
            end
            w = expected_exec.pop_front();
            if (got.result !== w.result) begin
                $error("result: expected %h, actual %h", w.result, got.result);
                errors++;
            end
            if (got.write_back !== w.write_back) begin
                $error("write_back: expected %b, actual %b", w.write_back, got.write_back);
                errors++;
            end
            if (got.status !== w.status) begin
                $error("status: expected %h, actual %h", w.status, got.status);
                errors++;
            end
            if (got.branch_taken !== w.branch_taken) begin
                $error("branch_taken: expected %b, actual %b", w.branch_taken,
                       got.branch_taken);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   idle_pct;
    int   cycle_count;

    exec_scoreboard sb;

    logic [7:0] reg_ops [53] = '{
        OP_LDX_IMM, OP_LDX_ZP, OP_LDX_ZPY, OP_LDX_ABS, OP_LDX_ABY,
        OP_LDY_IMM, OP_LDY_ZP, OP_LDY_ZPX, OP_LDY_ABS, OP_LDY_ABX,
        OP_STX_ZP, OP_STX_ZPY, OP_STX_ABS, OP_STY_ZP, OP_STY_ZPX, OP_STY_ABS,
        OP_TAX, OP_TAY, OP_TXA, OP_TYA, OP_TXS, OP_TSX,
        OP_PHA, OP_PHP, OP_PLA, OP_PLP, OP_INX, OP_INY, OP_DEX, OP_DEY,
        OP_BIT_ZP, OP_BIT_ABS, OP_CPX_IMM, OP_CPX_ZP, OP_CPX_ABS,
        OP_CPY_IMM, OP_CPY_ZP, OP_CPY_ABS,
        OP_CLC, OP_CLD, OP_CLI, OP_CLV, OP_SEC, OP_SED, OP_SEI,
        OP_BPL, OP_BMI, OP_BVC, OP_BVS, OP_BCC, OP_BCS, OP_BNE, OP_BEQ
    };

    cra_in_if  in_ch ();
    cra_out_if out_ch ();

    cpu_register_alu_execute u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_instruction(input logic [7:0] op, input logic [7:0] m);
        int gap;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 10);
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.operation <= op;
        in_ch.operand <= m;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_instruction(op, m);
        @(negedge clk);
    endtask

    function automatic logic [7:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return $urandom_range(0, 1) ? 8'h80 : 8'h7F;
            3, 4: return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_opcode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return {3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), CC_ACC};
        else if (r < 50) return {3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), CC_SHIFT};
        else if (r < 85) return reg_ops[$urandom_range(0, 52)];
        else return 8'($urandom_range(0, 255));
    endfunction

    // result side: stall in random bursts while idling is enabled
    initial begin
        int stall_left;
        stall_left = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
                stall_left = $urandom_range(1, 10) - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        t_exec got;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got.result = out_ch.result;
            got.write_back = out_ch.write_back;
            got.status = out_ch.status;
            got.branch_taken = out_ch.branch_taken;
            sb.check_result(got);
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin
        sb = new();
        rst_n = 1'b0;
        idle_pct = 0;
        in_ch.valid = 1'b0;
        in_ch.operation = 8'h00;
        in_ch.operand = 8'h00;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed opening: operand extremes, carry and overflow, decimal mode,
        // memory and accumulator shifts, stack, transfers, unlisted opcodes
        idle_pct = 30;
        send_instruction(OP_LDA_IMM, 8'h00);
        send_instruction(OP_LDA_IMM, 8'hFF);
        send_instruction(OP_STA_IMM, 8'h55);
        send_instruction(OP_STA_ABS, 8'h00);
        send_instruction(OP_ADC_IMM, 8'h01);
        send_instruction(OP_LDA_IMM, 8'h7F);
        send_instruction(OP_ADC_IMM, 8'h01);
        send_instruction(OP_ORA_IMM, 8'h00);
        send_instruction(OP_EOR_IMM, 8'hFF);
        send_instruction(OP_SED, 8'h00);
        send_instruction(OP_LDA_IMM, 8'h99);
        send_instruction(OP_ADC_IMM, 8'h01);
        send_instruction(OP_SBC_IMM, 8'h01);
        send_instruction(OP_CLD, 8'h00);
        send_instruction(OP_ASL_ACC, 8'hFF);
        send_instruction(OP_ROR_ABS, 8'h01);
        send_instruction(OP_INC_ABS, 8'hFF);
        send_instruction(OP_DEC_ABS, 8'h00);
        send_instruction(OP_BIT_ABS, 8'hC0);
        send_instruction(OP_CMP_IMM, 8'h80);
        send_instruction(OP_PHP, 8'h00);
        send_instruction(OP_PLP, 8'hFF);
        send_instruction(OP_PLA, 8'h80);
        send_instruction(OP_TXS, 8'h00);
        send_instruction(OP_TSX, 8'h00);
        send_instruction(OP_BEQ, 8'h00);
        send_instruction(OP_JMP_ABS, 8'h12);
        send_instruction(OP_UNDOC_FF, 8'hFF);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            // alternate light, quiet and heavy idling; none in the tail
            if (i >= RANDOM_ITEMS - QUIET_TAIL) idle_pct = 0;
            else case ((i / 100) % 3)
                0: idle_pct = 15;
                1: idle_pct = 0;
                default: idle_pct = 50;
            endcase
            send_instruction(pick_opcode(), pick_operand());
        end
        in_ch.valid <= 1'b0;
        idle_pct = 0;

        while (sb.expected_exec.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.expected_exec.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/cra_pkg.sv
hw/rtl/cra_if.sv
hw/rtl/cra_alu.sv
hw/rtl/cpu_register_alu_execute.sv
tb/tb_cpu_register_alu_execute.sv
